@@ rtl/kt2_pkg.sv @@
package kt2_pkg;

    // Fixed widths of the item fields and the defaults of the top-level parameters.
    localparam int DATA_BITS      = 32;
    localparam int WORD_BITS_DEF  = 32;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int ADDR_BITS      = 5;
    localparam int STEP_BITS      = 4;
    localparam logic [STEP_BITS-1:0] LAST_STEP = 4'd11;

    // Values of the registers after reset.
    localparam logic [30:0]        RST_VAR  = 31'd524288;
    localparam logic [30:0]        RST_DT   = 31'd655;
    localparam logic signed [31:0] RST_IPOS = -32'sd2621440;
    localparam logic signed [31:0] RST_ISPD = 32'sd4587520;
    localparam logic [30:0]        RST_IVP  = 31'd26214;
    localparam logic [30:0]        RST_IVS  = 31'd1966080;

    // Register indexes on the configuration port.
    typedef enum logic [2:0] {
        REG_VAR  = 3'd0,
        REG_DT   = 3'd1,
        REG_IPOS = 3'd2,
        REG_ISPD = 3'd3,
        REG_IVP  = 3'd4,
        REG_IVS  = 3'd5
    } t_reg_idx;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SETUP,
        ST_DIV0_GO,
        ST_DIV0_WAIT,
        ST_DIV1_GO,
        ST_DIV1_WAIT,
        ST_MAC_GO,
        ST_MAC_W1,
        ST_MAC_W2,
        ST_DONE
    } t_state;

    // Operand and destination selects of the shared multiply-accumulate unit.
    typedef enum logic [4:0] {
        SEL_POS, SEL_SPD, SEL_CA, SEL_CB, SEL_CC, SEL_CD,
        SEL_K0, SEL_K1, SEL_INNOV,
        SEL_TA, SEL_TB, SEL_TC, SEL_TD, SEL_TE, SEL_TF,
        SEL_ONE, SEL_DT, SEL_Z
    } t_sel;

    // One step: dst = c +/- round(a * b).
    typedef struct packed {
        t_sel a;
        t_sel b;
        t_sel c;
        logic sub;
        t_sel dst;
    } t_op;

    // Request towards the multiply-accumulate unit.
    typedef struct packed {
        logic                   go;
        logic signed [31:0]     a;
        logic signed [31:0]     b;
        logic signed [31:0]     c;
        logic                   sub;
    } t_mac_req;

    typedef struct packed {
        logic signed [31:0] val;
        logic               ovf;
    } t_sat;

    // Clamp a wide value into the signed range of eff bits.
    function automatic t_sat sat_w(input logic signed [65:0] v, input int eff);
        logic signed [65:0] hi;
        logic signed [65:0] lo;
        t_sat r;
        hi = (66'sd1 <<< (eff - 1)) - 66'sd1;
        lo = -hi - 66'sd1;
        if (v > hi) begin
            r.val = hi[31:0];
            r.ovf = 1'b1;
        end else if (v < lo) begin
            r.val = lo[31:0];
            r.ovf = 1'b1;
        end else begin
            r.val = v[31:0];
            r.ovf = 1'b0;
        end
        return r;
    endfunction

    // Step programme of the update and predict stages.
    function automatic t_op op_of(input logic [STEP_BITS-1:0] step);
        t_op o;
        case (step)
            4'd0:    o = '{SEL_POS, SEL_ONE,   SEL_Z,   1'b1, SEL_INNOV};
            4'd1:    o = '{SEL_K0,  SEL_INNOV, SEL_POS, 1'b0, SEL_POS};
            4'd2:    o = '{SEL_K1,  SEL_INNOV, SEL_SPD, 1'b0, SEL_SPD};
            4'd3:    o = '{SEL_K0,  SEL_CA,    SEL_CA,  1'b1, SEL_TA};
            4'd4:    o = '{SEL_K0,  SEL_CB,    SEL_CB,  1'b1, SEL_TB};
            4'd5:    o = '{SEL_K1,  SEL_CA,    SEL_CC,  1'b1, SEL_TC};
            4'd6:    o = '{SEL_K1,  SEL_CB,    SEL_CD,  1'b1, SEL_TD};
            4'd7:    o = '{SEL_DT,  SEL_SPD,   SEL_POS, 1'b0, SEL_POS};
            4'd8:    o = '{SEL_DT,  SEL_TC,    SEL_TA,  1'b0, SEL_TE};
            4'd9:    o = '{SEL_DT,  SEL_TD,    SEL_TB,  1'b0, SEL_TF};
            4'd10:   o = '{SEL_DT,  SEL_TF,    SEL_TE,  1'b0, SEL_CA};
            default: o = '{SEL_DT,  SEL_TD,    SEL_TC,  1'b0, SEL_CC};
        endcase
        return o;
    endfunction

endpackage

@@ rtl/kalman_tracker_2state_unit.sv @@
// Channel   Direction  Handshake            Payload
// input     in         i_valid / o_stall    i_measurement, i_restart
// result    out        o_valid / i_stall    o_gain_*, o_est_*, o_cov_*, o_overflow
// config    in         psel/penable/pwrite  paddr, pwdata, prdata, pready
//
// An item runs a setup state, two runs of the bit-serial divider for the gains
// (skipped when the denominator is not positive), and twelve passes through the
// shared multiply-accumulate unit. The divider, when it runs, takes most of it.
// Reset (synchronous, active low) restores config, filter and sequencer state.
// o_stall is high from acceptance until the result is loaded into the output
// register; a held result delays the load of the next one.
module kalman_tracker_2state_unit #(
    parameter int WORD_BITS = kt2_pkg::WORD_BITS_DEF,
    parameter int FRAC_BITS = kt2_pkg::FRAC_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic signed [kt2_pkg::DATA_BITS-1:0] i_measurement,
    input  logic                             i_restart,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic signed [kt2_pkg::DATA_BITS-1:0] o_gain_pos,
    output logic signed [kt2_pkg::DATA_BITS-1:0] o_gain_spd,
    output logic signed [kt2_pkg::DATA_BITS-1:0] o_est_position,
    output logic signed [kt2_pkg::DATA_BITS-1:0] o_est_speed,
    output logic signed [kt2_pkg::DATA_BITS-1:0] o_cov_00,
    output logic signed [kt2_pkg::DATA_BITS-1:0] o_cov_01,
    output logic signed [kt2_pkg::DATA_BITS-1:0] o_cov_10,
    output logic signed [kt2_pkg::DATA_BITS-1:0] o_cov_11,
    output logic                             o_overflow,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [kt2_pkg::ADDR_BITS-1:0]    paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);
    import kt2_pkg::*;

    localparam int EFF_BITS = (WORD_BITS < 32) ? WORD_BITS : 32;
    localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;

    // Reset state, clamped to the working range.
    localparam t_sat RST_POS_Q = sat_w(66'(RST_IPOS), EFF_BITS);
    localparam t_sat RST_SPD_Q = sat_w(66'(RST_ISPD), EFF_BITS);
    localparam t_sat RST_CA_Q  = sat_w(66'({1'b0, RST_IVP}), EFF_BITS);
    localparam t_sat RST_CD_Q  = sat_w(66'({1'b0, RST_IVS}), EFF_BITS);

    t_state r_state;
    t_state n_state;
    logic [STEP_BITS-1:0] r_step;

    logic [30:0]        r_var, r_dt, r_ivp, r_ivs;
    logic signed [31:0] r_ipos, r_ispd;

    logic signed [31:0] r_pos, r_spd, r_ca, r_cb, r_cc, r_cd;
    logic signed [31:0] r_k0, r_k1, r_innov, r_z;
    logic signed [31:0] r_ta, r_tb, r_tc, r_td, r_te, r_tf;
    logic [31:0]        r_den;
    logic               r_den_ok;
    logic               r_ovf;
    logic signed [31:0] r_meas;
    logic               r_rs;

    logic               div_start;
    logic signed [31:0] div_num;
    logic               div_done;
    logic signed [65:0] div_quot;
    t_sat               q_sat;

    t_mac_req           mac_req;
    logic               mac_valid;
    logic signed [31:0] mac_res;
    logic               mac_ovf;
    t_op                op;

    logic               accept;
    logic               load_out;
    t_sat               ld_pos, ld_spd, ld_ca, ld_cd, ld_z;
    logic signed [31:0] ca_eff;
    logic signed [32:0] s_sum;

    assign accept = i_valid & ~o_stall;
    assign pready = 1'b1;

    // Configuration writes and reads.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_var  <= RST_VAR;
            r_dt   <= RST_DT;
            r_ipos <= RST_IPOS;
            r_ispd <= RST_ISPD;
            r_ivp  <= RST_IVP;
            r_ivs  <= RST_IVS;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[4:2])
                REG_VAR:  r_var  <= pwdata[30:0];
                REG_DT:   r_dt   <= pwdata[30:0];
                REG_IPOS: r_ipos <= pwdata;
                REG_ISPD: r_ispd <= pwdata;
                REG_IVP:  r_ivp  <= pwdata[30:0];
                REG_IVS:  r_ivs  <= pwdata[30:0];
                default:  ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            REG_VAR:  prdata = {1'b0, r_var};
            REG_DT:   prdata = {1'b0, r_dt};
            REG_IPOS: prdata = r_ipos;
            REG_ISPD: prdata = r_ispd;
            REG_IVP:  prdata = {1'b0, r_ivp};
            REG_IVS:  prdata = {1'b0, r_ivs};
            default:  prdata = 32'd0;
        endcase
    end

    // Restart values, entry clamp and the gain denominator.
    always_comb begin
        ld_pos = sat_w(66'(r_ipos), EFF_BITS);
        ld_spd = sat_w(66'(r_ispd), EFF_BITS);
        ld_ca  = sat_w(66'({1'b0, r_ivp}), EFF_BITS);
        ld_cd  = sat_w(66'({1'b0, r_ivs}), EFF_BITS);
        ld_z   = sat_w(66'(r_meas), EFF_BITS);
        ca_eff = r_rs ? ld_ca.val : r_ca;
        s_sum  = 33'(ca_eff) + 33'({1'b0, r_var});
    end

    // Next-state logic of the sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:      if (accept) n_state = ST_SETUP;
            ST_SETUP:     n_state = r_den_ok_next() ? ST_DIV0_GO : ST_MAC_GO;
            ST_DIV0_GO:   n_state = ST_DIV0_WAIT;
            ST_DIV0_WAIT: if (div_done) n_state = ST_DIV1_GO;
            ST_DIV1_GO:   n_state = ST_DIV1_WAIT;
            ST_DIV1_WAIT: if (div_done) n_state = ST_MAC_GO;
            ST_MAC_GO:    n_state = ST_MAC_W1;
            ST_MAC_W1:    n_state = ST_MAC_W2;
            ST_MAC_W2:    n_state = (r_step == LAST_STEP) ? ST_DONE : ST_MAC_GO;
            ST_DONE:      if (!o_valid || !i_stall) n_state = ST_IDLE;
            default:      n_state = ST_IDLE;
        endcase
    end

    function automatic logic r_den_ok_next();
        return (s_sum > 33'sd0);
    endfunction

    // Operand selection of the shared unit.
    function automatic logic signed [31:0] sel_val(input t_sel s);
        logic signed [31:0] v;
        case (s)
            SEL_POS:   v = r_pos;
            SEL_SPD:   v = r_spd;
            SEL_CA:    v = r_ca;
            SEL_CB:    v = r_cb;
            SEL_CC:    v = r_cc;
            SEL_CD:    v = r_cd;
            SEL_K0:    v = r_k0;
            SEL_K1:    v = r_k1;
            SEL_INNOV: v = r_innov;
            SEL_TA:    v = r_ta;
            SEL_TB:    v = r_tb;
            SEL_TC:    v = r_tc;
            SEL_TD:    v = r_td;
            SEL_TE:    v = r_te;
            SEL_TF:    v = r_tf;
            SEL_ONE:   v = ONE;
            SEL_DT:    v = {1'b0, r_dt};
            default:   v = r_z;
        endcase
        return v;
    endfunction

    // Control outputs of the sequencer.
    always_comb begin
        op          = op_of(r_step);
        div_start   = (r_state == ST_DIV0_GO) || (r_state == ST_DIV1_GO);
        div_num     = (r_state == ST_DIV1_GO) ? r_cc : r_ca;
        mac_req.go  = (r_state == ST_MAC_GO);
        mac_req.a   = sel_val(op.a);
        mac_req.b   = sel_val(op.b);
        mac_req.c   = sel_val(op.c);
        mac_req.sub = op.sub;
        load_out    = (r_state == ST_DONE) && (!o_valid || !i_stall);
        o_stall     = (r_state != ST_IDLE);
        q_sat       = sat_w(div_quot, EFF_BITS);
    end

    kt2_div #(
        .FRAC_BITS(FRAC_BITS)
    ) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(div_start),
        .i_num  (div_num),
        .i_den  (r_den),
        .o_done (div_done),
        .o_quot (div_quot)
    );

    kt2_mac #(
        .FRAC_BITS(FRAC_BITS),
        .EFF_BITS (EFF_BITS)
    ) u_mac (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (mac_req),
        .o_valid(mac_valid),
        .o_res  (mac_res),
        .o_ovf  (mac_ovf)
    );

    // Sequencer state and step counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_SETUP) begin
                r_step <= '0;
            end else if (r_state == ST_MAC_W2 && r_step != LAST_STEP) begin
                r_step <= r_step + 4'd1;
            end
        end
    end

    // Filter state and working registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= RST_POS_Q.val;
            r_spd <= RST_SPD_Q.val;
            r_ca  <= RST_CA_Q.val;
            r_cb  <= 32'sd0;
            r_cc  <= 32'sd0;
            r_cd  <= RST_CD_Q.val;
        end else begin
            if (r_state == ST_SETUP && r_rs) begin
                r_pos <= ld_pos.val;
                r_spd <= ld_spd.val;
                r_ca  <= ld_ca.val;
                r_cb  <= 32'sd0;
                r_cc  <= 32'sd0;
                r_cd  <= ld_cd.val;
            end
            if (r_state == ST_MAC_W2 && mac_valid) begin
                case (op.dst)
                    SEL_POS: r_pos <= mac_res;
                    SEL_SPD: r_spd <= mac_res;
                    SEL_CA:  r_ca  <= mac_res;
                    SEL_CC:  r_cc  <= mac_res;
                    default: ;
                endcase
            end
            if (load_out) begin
                r_cb <= r_tf;
                r_cd <= r_td;
            end
        end
    end

    // Item-local registers: captured item, gains, temporaries and the flag.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_meas <= i_measurement;
            r_rs   <= i_restart;
        end
        if (r_state == ST_SETUP) begin
            r_z      <= ld_z.val;
            r_den    <= s_sum[31:0];
            r_den_ok <= (s_sum > 33'sd0);
            r_k0     <= 32'sd0;
            r_k1     <= 32'sd0;
            r_ovf    <= ld_z.ovf | (s_sum <= 33'sd0) |
                        (r_rs & (ld_pos.ovf | ld_spd.ovf | ld_ca.ovf | ld_cd.ovf));
        end
        if (r_state == ST_DIV0_WAIT && div_done) begin
            r_k0  <= q_sat.val;
            r_ovf <= r_ovf | q_sat.ovf;
        end
        if (r_state == ST_DIV1_WAIT && div_done) begin
            r_k1  <= q_sat.val;
            r_ovf <= r_ovf | q_sat.ovf;
        end
        if (r_state == ST_MAC_W2 && mac_valid) begin
            r_ovf <= r_ovf | mac_ovf;
            case (op.dst)
                SEL_INNOV: r_innov <= mac_res;
                SEL_TA:    r_ta    <= mac_res;
                SEL_TB:    r_tb    <= mac_res;
                SEL_TC:    r_tc    <= mac_res;
                SEL_TD:    r_td    <= mac_res;
                SEL_TE:    r_te    <= mac_res;
                SEL_TF:    r_tf    <= mac_res;
                default:   ;
            endcase
        end
    end

    // Output register of the result channel.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (load_out) begin
            o_valid <= 1'b1;
        end else if (!i_stall) begin
            o_valid <= 1'b0;
        end
        if (load_out) begin
            o_gain_pos     <= r_k0;
            o_gain_spd     <= r_k1;
            o_est_position <= r_pos;
            o_est_speed    <= r_spd;
            o_cov_00       <= r_ca;
            o_cov_01       <= r_tf;
            o_cov_10       <= r_cc;
            o_cov_11       <= r_td;
            o_overflow     <= r_ovf;
        end
    end

    // The divider only reports while the sequencer waits for it.
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == ST_DIV0_WAIT || r_state == ST_DIV1_WAIT))
        else $error("divider result outside a wait state");

    // A unit result lands exactly in the write-back state.
    a_mac_wb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mac_valid |-> (r_state == ST_MAC_W2))
        else $error("unit result outside write-back");

    // The step counter stays within the programme.
    a_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step <= LAST_STEP)
        else $error("step counter beyond programme");

    // An accepted item starts the setup cycle.
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == ST_SETUP))
        else $error("accepted item did not start");

    // A skipped gain leaves both gains at zero.
    a_den_skip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MAC_GO && !r_den_ok) |-> (r_k0 == 32'sd0 && r_k1 == 32'sd0))
        else $error("gain set with non-positive denominator");

endmodule

@@ rtl/kt2_mac.sv @@
module kt2_mac #(
    parameter int FRAC_BITS = 16,
    parameter int EFF_BITS  = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  kt2_pkg::t_mac_req    i_req,
    output logic                 o_valid,
    output logic signed [31:0]   o_res,
    output logic                 o_ovf
);
    import kt2_pkg::*;

    logic signed [63:0] r_prod;
    logic signed [31:0] r_c;
    logic               r_sub;
    logic               r_v1;
    logic signed [65:0] rnd;
    logic signed [65:0] shf;
    logic signed [65:0] sum;
    t_sat               m_sat;
    t_sat               s_sat;

    // First stage: the product.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= i_req.go;
        end
        r_prod <= i_req.a * i_req.b;
        r_c    <= i_req.c;
        r_sub  <= i_req.sub;
    end

    // Second stage: round to nearest, clamp, then add or subtract and clamp again.
    always_comb begin
        rnd   = 66'(r_prod) + (66'sd1 <<< (FRAC_BITS - 1));
        shf   = rnd >>> FRAC_BITS;
        m_sat = sat_w(shf, EFF_BITS);
        if (r_sub) begin
            sum = 66'(r_c) - 66'(m_sat.val);
        end else begin
            sum = 66'(r_c) + 66'(m_sat.val);
        end
        s_sat = sat_w(sum, EFF_BITS);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_v1;
        end
        o_res <= s_sat.val;
        o_ovf <= m_sat.ovf | s_sat.ovf;
    end

endmodule

@@ rtl/kt2_div.sv @@
module kt2_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic signed [31:0]   i_num,
    input  logic [31:0]          i_den,
    output logic                 o_done,
    output logic signed [65:0]   o_quot
);
    import kt2_pkg::*;

    logic [63:0] r_mag;
    logic [31:0] r_rem;
    logic [63:0] r_quo;
    logic [31:0] r_den;
    logic        r_neg;
    logic [6:0]  r_cnt;
    logic        r_busy;
    logic [31:0] mag;
    logic [32:0] trial;
    logic        qbit;
    logic [32:0] diff;

    // Restoring division, one quotient bit a cycle.
    always_comb begin
        mag   = i_num[31] ? (~i_num + 32'd1) : i_num;
        trial = {r_rem, r_mag[63]};
        diff  = trial - {1'b0, r_den};
        qbit  = (trial >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= 7'd0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 7'd64;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
        if (i_start) begin
            r_mag <= 64'(mag) << FRAC_BITS;
            r_rem <= 32'd0;
            r_quo <= 64'd0;
            r_den <= i_den;
            r_neg <= i_num[31];
        end else if (r_busy) begin
            r_mag <= {r_mag[62:0], 1'b0};
            r_rem <= qbit ? diff[31:0] : trial[31:0];
            r_quo <= {r_quo[62:0], qbit};
        end
    end

    // Quotient truncated toward zero.
    assign o_quot = r_neg ? -$signed({2'b00, r_quo}) : $signed({2'b00, r_quo});

endmodule

@@ dv/kalman_tracker_2state_unit_tb.sv @@
`timescale 1ns / 1ps

module kalman_tracker_2state_unit_tb;
    import kt2_pkg::*;

    localparam int WDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 400;

    typedef struct {
        logic signed [31:0] gain_pos;
        logic signed [31:0] gain_spd;
        logic signed [31:0] est_position;
        logic signed [31:0] est_speed;
        logic signed [31:0] cov_00;
        logic signed [31:0] cov_01;
        logic signed [31:0] cov_10;
        logic signed [31:0] cov_11;
        logic               overflow;
    } track_out_t;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_stall;
    logic signed [31:0]   i_measurement;
    logic                 i_restart;
    logic                 o_valid;
    logic                 i_stall;
    logic signed [31:0]   o_gain_pos;
    logic signed [31:0]   o_gain_spd;
    logic signed [31:0]   o_est_position;
    logic signed [31:0]   o_est_speed;
    logic signed [31:0]   o_cov_00;
    logic signed [31:0]   o_cov_01;
    logic signed [31:0]   o_cov_10;
    logic signed [31:0]   o_cov_11;
    logic                 o_overflow;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [ADDR_BITS-1:0] paddr;
    logic [31:0]          pwdata;
    logic [31:0]          prdata;
    logic                 pready;

    // Register copies and filter state held by the predictor.
    longint noise_var, step_dt, start_pos, start_spd, start_vpos, start_vspd;
    longint trk_pos, trk_spd, trk_p00, trk_p01, trk_p10, trk_p11;
    bit     sat_hit;

    track_out_t expected_tracks[$];
    int  mismatches;
    int  items_sent;
    int  tracks_checked;
    int  restarts_sent;
    int  overflow_steps;
    int  idle_cycles;
    bit  calm;

    kalman_tracker_2state_unit dut (.*);

    // Clock with a 4 ns period.
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Clamp to the signed 32-bit range, noting any change.
    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647) begin
            sat_hit = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            sat_hit = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    // Fixed-point product, rounded to nearest with ties upwards.
    function automatic longint qmul(input longint a, input longint b);
        longint p;
        p = a * b + 64'sd32768;
        return clamp32(p >>> 16);
    endfunction

    // Fixed-point quotient, truncated towards zero.
    function automatic longint qdiv(input longint num, input longint den);
        return clamp32((num * 64'sd65536) / den);
    endfunction

    function automatic void reload_track();
        trk_pos = clamp32(start_pos);
        trk_spd = clamp32(start_spd);
        trk_p00 = clamp32(start_vpos);
        trk_p01 = 0;
        trk_p10 = 0;
        trk_p11 = clamp32(start_vspd);
    endfunction

    // One filter step: update with the measurement, then predict.
    function automatic track_out_t predict_track(input logic signed [31:0] z, input logic rs);
        longint s, k0, k1, innov, ta, tb, tc, td, te, tf;
        track_out_t t;
        sat_hit = 1'b0;
        if (rs)
            reload_track();
        k0 = 0;
        k1 = 0;
        s = trk_p00 + noise_var;
        if (s <= 0) begin
            sat_hit = 1'b1;
        end else begin
            k0 = qdiv(trk_p00, s);
            k1 = qdiv(trk_p10, s);
        end
        innov = clamp32(longint'(z) - trk_pos);
        trk_pos = clamp32(trk_pos + qmul(k0, innov));
        trk_spd = clamp32(trk_spd + qmul(k1, innov));
        ta = clamp32(trk_p00 - qmul(k0, trk_p00));
        tb = clamp32(trk_p01 - qmul(k0, trk_p01));
        tc = clamp32(trk_p10 - qmul(k1, trk_p00));
        td = clamp32(trk_p11 - qmul(k1, trk_p01));
        trk_pos = clamp32(trk_pos + qmul(step_dt, trk_spd));
        te = clamp32(ta + qmul(step_dt, tc));
        tf = clamp32(tb + qmul(step_dt, td));
        trk_p00 = clamp32(te + qmul(step_dt, tf));
        trk_p01 = tf;
        trk_p10 = clamp32(tc + qmul(step_dt, td));
        trk_p11 = td;
        t.gain_pos = k0[31:0];
        t.gain_spd = k1[31:0];
        t.est_position = trk_pos[31:0];
        t.est_speed = trk_spd[31:0];
        t.cov_00 = trk_p00[31:0];
        t.cov_01 = trk_p01[31:0];
        t.cov_10 = trk_p10[31:0];
        t.cov_11 = trk_p11[31:0];
        t.overflow = sat_hit;
        return t;
    endfunction

    // Register write over the configuration port; the block must be idle.
    task automatic write_reg(input t_reg_idx idx, input logic [31:0] val);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_VAR:  noise_var = longint'(val[30:0]);
            REG_DT:   step_dt = longint'(val[30:0]);
            REG_IPOS: start_pos = longint'(signed'(val));
            REG_ISPD: start_spd = longint'(signed'(val));
            REG_IVP:  start_vpos = longint'(val[30:0]);
            default:  start_vspd = longint'(val[30:0]);
        endcase
    endtask

    task automatic write_all(input logic [31:0] r, input logic [31:0] dt,
                             input logic [31:0] ip, input logic [31:0] is,
                             input logic [31:0] vp, input logic [31:0] vs);
        write_reg(REG_VAR, r);
        write_reg(REG_DT, dt);
        write_reg(REG_IPOS, ip);
        write_reg(REG_ISPD, is);
        write_reg(REG_IVP, vp);
        write_reg(REG_IVS, vs);
    endtask

    task automatic wait_idle();
        while (expected_tracks.size() != 0)
            @(posedge i_clk);
    endtask

    // Send one measurement item, predicting its result on acceptance.
    task automatic send_measurement(input logic signed [31:0] z, input logic rs);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_measurement <= z;
        i_restart <= rs;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        expected_tracks.push_back(predict_track(z, rs));
        items_sent++;
        if (rs)
            restarts_sent++;
    endtask

    task automatic end_burst();
        i_valid <= 1'b0;
        wait_idle();
    endtask

    task automatic check_field(input string nm, input logic signed [31:0] e,
                               input logic signed [31:0] a);
        if (e !== a) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch on %s (track %0d): expected %0d, got %0d",
                         nm, tracks_checked, e, a);
        end
    endtask

    // Result side: random stall per item, compare each accepted result.
    initial begin
        int n;
        track_out_t e;
        i_stall = 1'b1;
        @(posedge i_rst_n);
        forever begin
            n = calm ? 0 : $urandom_range(0, 10);
            if (n > 0) begin
                i_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_valid)
                @(posedge i_clk);
            if (expected_tracks.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: result arrived with nothing expected");
            end else begin
                e = expected_tracks.pop_front();
                check_field("gain_pos", e.gain_pos, o_gain_pos);
                check_field("gain_spd", e.gain_spd, o_gain_spd);
                check_field("est_position", e.est_position, o_est_position);
                check_field("est_speed", e.est_speed, o_est_speed);
                check_field("cov_00", e.cov_00, o_cov_00);
                check_field("cov_01", e.cov_01, o_cov_01);
                check_field("cov_10", e.cov_10, o_cov_10);
                check_field("cov_11", e.cov_11, o_cov_11);
                check_field("overflow", 32'(e.overflow), 32'(o_overflow));
                if (e.overflow)
                    overflow_steps++;
            end
            tracks_checked++;
        end
    end

    // Watchdog on cycles with no handshake, no configuration access and no reset.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || psel || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WDOG_LIMIT) begin
            $display("watchdog expired with %0d results outstanding",
                     expected_tracks.size());
            $display("end of test: mismatches");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Reset values, then a plain track and a restart.
    task automatic test_defaults();
        send_measurement(-32'sd2621440, 1'b0);
        send_measurement(-32'sd2555904, 1'b0);
        send_measurement(-32'sd2490368, 1'b1);
        send_measurement(32'sd0, 1'b0);
        end_burst();
    endtask

    // Measurement extremes, which drive the innovation into saturation.
    task automatic test_measurement_extremes();
        calm = 1'b1;
        send_measurement(32'sh7fffffff, 1'b0);
        send_measurement(-32'sh80000000, 1'b0);
        send_measurement(-32'sd1, 1'b1);
        send_measurement(32'sh7fffffff, 1'b1);
        send_measurement(-32'sh80000000, 1'b1);
        calm = 1'b0;
        end_burst();
    endtask

    // A zero denominator: no measurement noise and no position variance.
    task automatic test_zero_denominator();
        write_all(32'd0, 32'd655, 32'd0, 32'd65536, 32'd0, 32'd65536);
        send_measurement(32'sd65536, 1'b1);
        send_measurement(32'sd131072, 1'b0);
        send_measurement(-32'sd65536, 1'b0);
        end_burst();
    endtask

    // Register extremes: largest values everywhere, then the lowest, then a mixed setting.
    task automatic test_register_extremes();
        write_all(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                  32'h7fffffff, 32'h7fffffff);
        send_measurement(32'sd12345, 1'b1);
        send_measurement(-32'sd98765, 1'b0);
        send_measurement(32'sh7fffffff, 1'b0);
        end_burst();
        write_all(32'd1, 32'd0, 32'h80000000, 32'h80000000, 32'd1, 32'd0);
        send_measurement(32'sh7fffffff, 1'b1);
        send_measurement(-32'sh80000000, 1'b0);
        send_measurement(32'sd0, 1'b0);
        end_burst();
        write_all(32'hffffffff, 32'd65536, 32'd0, 32'hffff0000, 32'h80000000,
                  32'hffffffff);
        send_measurement(32'sd65536, 1'b1);
        send_measurement(32'sd0, 1'b0);
        end_burst();
    endtask

    function automatic logic [31:0] pick_word(input logic [31:0] typical);
        case ($urandom_range(0, 5))
            0:       return $urandom();
            1:       return 32'h7fffffff;
            2:       return 32'd0;
            default: return typical;
        endcase
    endfunction

    // Random tracks across several register settings.
    task automatic test_random_tracks(input int total);
        int per_phase;
        logic signed [31:0] z;
        per_phase = total / 8;
        for (int ph = 0; ph < 8; ph++) begin
            write_all(pick_word($urandom_range(1, 2000000)),
                      pick_word($urandom_range(1, 20000)),
                      pick_word($urandom_range(0, 20000000) - 10000000),
                      pick_word($urandom_range(0, 20000000) - 10000000),
                      pick_word($urandom_range(1, 5000000)),
                      pick_word($urandom_range(1, 5000000)));
            calm = (ph == 3);
            for (int i = 0; i < per_phase; i++) begin
                if ($urandom_range(0, 19) == 0)
                    end_burst();
                if ($urandom_range(0, 4) == 0)
                    z = $urandom();
                else
                    z = trk_pos[31:0] + $signed($urandom_range(0, 400000)) - 200000;
                send_measurement(z, (i == 0) || ($urandom_range(0, 11) == 0));
            end
            calm = 1'b0;
            end_burst();
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_measurement = '0;
        i_restart = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        calm = 1'b0;
        mismatches = 0;
        items_sent = 0;
        tracks_checked = 0;
        restarts_sent = 0;
        overflow_steps = 0;
        idle_cycles = 0;
        expected_tracks.delete();
        noise_var = RST_VAR;
        step_dt = RST_DT;
        start_pos = RST_IPOS;
        start_spd = RST_ISPD;
        start_vpos = RST_IVP;
        start_vspd = RST_IVS;
        reload_track();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_defaults();
        test_measurement_extremes();
        test_zero_denominator();
        test_register_extremes();
        test_random_tracks(650);

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Ran %0d measurements (%0d restarts) over 13 register settings.",
                 items_sent, restarts_sent);
        $display("Checked %0d results, %0d of them flagging overflow.",
                 tracks_checked, overflow_steps);
        if (mismatches == 0 && expected_tracks.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
